// ----- rtl/bba_pkg.sv -----
// Package for the bitmap block allocator: sizes, opcodes, status codes.
// No dependencies.
package bba_pkg;
  localparam int unsigned NumBlocksDef = 4096;
  localparam int unsigned WordBitsDef  = 32;
  localparam int unsigned BaseW  = 12;
  localparam int unsigned CountW = 13;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [BaseW-1:0]  base_block;
    logic [CountW-1:0] block_count;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BaseW-1:0] start_block;
    logic             block_state;
  } rsp_t;
endpackage

// ----- rtl/bba_if.sv -----
// Valid/ready channel interfaces for requests, results and config writes.
// Depends on bba_pkg.
interface bba_req_if;
  logic          valid;
  logic          ready;
  bba_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bba_rsp_if;
  logic          valid;
  logic          ready;
  bba_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bba_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bitmap_block_allocator.sv -----
// Bitmap block allocator top level: sequencer around the bitmap RAM.
// Depends on bba_pkg, bba_if, bba_map_ram.
// Reset clears the control state, then a clearing pass writes all-ones to
// every word, during which no item is taken.
// One item at a time. Query: RAM read, then result. Free/reserve: read, latch
// and write back each touched word. Allocate: each word scanned is read, latched, then
// examined one block per cycle; the run found is then marked like a reserve.
module bitmap_block_allocator #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::NumBlocksDef,
  parameter int unsigned WORD_BITS  = bba_pkg::WordBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o,
  bba_cfg_if.sink   cfg_i
);
  import bba_pkg::*;

  localparam int unsigned Words = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  // block index width, enough to hold NUM_BLOCKS itself
  localparam int unsigned IW = $clog2(NUM_BLOCKS + 1) + 1;
  localparam logic [IW-1:0] NB = IW'(NUM_BLOCKS);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HINTR = 4'd2;
  localparam logic [3:0] S_HINTW = 4'd3;
  localparam logic [3:0] S_SCANR = 4'd4;
  localparam logic [3:0] S_SCANW = 4'd5;
  localparam logic [3:0] S_SCANB = 4'd6;
  localparam logic [3:0] S_MARKR = 4'd7;
  localparam logic [3:0] S_MARKW = 4'd8;
  localparam logic [3:0] S_MARKM = 4'd9;
  localparam logic [3:0] S_QRYR  = 4'd10;
  localparam logic [3:0] S_QRYW  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]          state_q, state_d;
  logic [1:0]          policy_q;
  logic [IW-1:0]       hint_q, hint_d;
  req_t                req_q, req_d;
  rsp_t                rsp_q, rsp_d;
  logic                mark_used_q, mark_used_d;
  logic [IW-1:0]       cur_q, cur_d;       // current block of scan/mark
  logic [IW-1:0]       end_q, end_d;       // mark end (exclusive)
  logic [IW-1:0]       it_q, it_d;         // scan iteration count
  logic [IW-1:0]       rstart_q, rstart_d; // start of current free run
  logic [IW-1:0]       rlen_q, rlen_d;
  logic [IW-1:0]       pick_q, pick_d;
  logic [IW-1:0]       plen_q, plen_d;
  logic                have_q, have_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [AW-1:0]       clr_q, clr_d;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  bba_map_ram #(.Words(Words), .WordBits(WORD_BITS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = (state_q == S_OUT);
  assign rsp_o.data  = rsp_q;

  // block index helpers
  function automatic logic [AW-1:0] widx(input logic [IW-1:0] b);
    widx = AW'(b >> BW);
  endfunction
  function automatic logic [BW-1:0] bidx(input logic [IW-1:0] b);
    bidx = b[BW-1:0];
  endfunction

  logic [IW-1:0] cnt_ext, cur_next, scan_blk, len_new;
  logic          bit_free, is_last, done_run, better, in_map;

  always_comb begin
    state_d = state_q; hint_d = hint_q; req_d = req_q; rsp_d = rsp_q;
    mark_used_d = mark_used_q; cur_d = cur_q; end_d = end_q; it_d = it_q;
    rstart_d = rstart_q; rlen_d = rlen_q; pick_d = pick_q; plen_d = plen_q;
    have_d = have_q; word_d = word_q; clr_d = clr_q;
    we = 1'b0; waddr = widx(cur_q); wdata = word_q; raddr = widx(cur_q);
    cnt_ext = IW'(req_q.block_count);
    cur_next = cur_q + IW'(1);
    scan_blk = cur_q;
    bit_free = 1'b0; is_last = 1'b0; done_run = 1'b0; better = 1'b0;
    len_new = '0; in_map = 1'b0;

    unique case (state_q)
      S_CLR: begin
        we = 1'b1; waddr = clr_q; wdata = '1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Words - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid) begin
          req_d = req_i.data;
          rsp_d = '0;
          cnt_ext = IW'(req_i.data.block_count);
          cur_d = IW'(req_i.data.base_block);
          end_d = IW'(req_i.data.base_block) + IW'(req_i.data.block_count);
          if (end_d > NB) end_d = NB;
          unique case (req_i.data.opcode)
            OP_ALLOC: begin
              mark_used_d = 1'b1;
              it_d = '0; rlen_d = '0; rstart_d = '0; have_d = 1'b0;
              pick_d = '0; plen_d = '0;
              if (req_i.data.block_count == '0) begin
                rsp_d.status = ST_ZERO; state_d = S_OUT;
              end else if (cnt_ext > NB) begin
                rsp_d.status = ST_NOFIT; state_d = S_OUT;
                if (policy_q == FIT_NEXT && hint_q != '0) begin
                  cur_d = hint_q - IW'(1); state_d = S_HINTR;
                end
              end else if (policy_q == FIT_NEXT && hint_q != '0) begin
                cur_d = hint_q - IW'(1); state_d = S_HINTR;
              end else begin
                cur_d = (policy_q == FIT_NEXT) ? hint_q : '0;
                state_d = S_SCANR;
              end
            end
            OP_FREE, OP_RESERVE: begin
              mark_used_d = (req_i.data.opcode == OP_RESERVE);
              state_d = (cur_d < end_d) ? S_MARKR : S_OUT;
            end
            default: begin
              if (IW'(req_i.data.base_block) >= NB) begin
                rsp_d.block_state = 1'b1; state_d = S_OUT;
              end else begin
                state_d = S_QRYR;
              end
            end
          endcase
        end
      end
      S_HINTR: state_d = S_HINTW;
      S_HINTW: begin
        if (!rdata[bidx(cur_q)]) hint_d = '0;
        if (rsp_q.status == ST_NOFIT) begin
          state_d = S_OUT;
        end else begin
          cur_d = rdata[bidx(cur_q)] ? hint_q : '0;
          state_d = S_SCANR;
        end
      end
      S_SCANR: state_d = S_SCANW;
      S_SCANW: begin
        word_d = rdata; state_d = S_SCANB;
      end
      S_SCANB: begin
        // one block per cycle from the latched word
        in_map = (cur_q < NB);
        bit_free = in_map && !word_q[bidx(cur_q)];
        len_new = bit_free ? rlen_q + IW'(1) : '0;
        if (policy_q == FIT_FIRST || policy_q == FIT_NEXT) begin
          if (bit_free) begin
            if (rlen_q == '0) rstart_d = cur_q;
            rlen_d = len_new;
            if (len_new >= cnt_ext) begin
              pick_d = (rlen_q == '0) ? cur_q : rstart_q;
              have_d = 1'b1;
              done_run = 1'b1;
            end
          end else begin
            rlen_d = '0;
          end
          it_d = it_q + IW'(1);
          is_last = (it_q + IW'(1) >= NB);
          if (done_run) begin
            if (policy_q == FIT_NEXT) begin
              hint_d = ((pick_d + IW'(1)) >= NB) ? '0 : pick_d + IW'(1);
            end
            cur_d = pick_d; end_d = pick_d + cnt_ext;
            state_d = S_MARKR;
          end else if (is_last) begin
            rsp_d.status = ST_NOFIT; state_d = S_OUT;
          end else begin
            cur_d = (cur_next >= NB) ? '0 : cur_next;
            if (cur_next >= NB) rlen_d = '0;
            if (cur_d[BW-1:0] == '0) state_d = S_SCANR;
          end
        end else begin
          // best/worst fit: close a run on the first used block or the end
          if (bit_free) begin
            if (rlen_q == '0) rstart_d = cur_q;
            rlen_d = len_new;
          end else begin
            rlen_d = '0;
            if (rlen_q != '0 && rlen_q >= cnt_ext) begin
              better = (policy_q == FIT_WORST) ? (rlen_q > plen_q) : (rlen_q < plen_q);
              if (!have_q || better) begin
                pick_d = rstart_q; plen_d = rlen_q; have_d = 1'b1;
              end
            end
          end
          if (!in_map) begin
            if (have_d) begin
              cur_d = pick_d; end_d = pick_d + cnt_ext; state_d = S_MARKR;
            end else begin
              rsp_d.status = ST_NOFIT; state_d = S_OUT;
            end
          end else begin
            cur_d = cur_next;
            if (cur_next[BW-1:0] == '0) state_d = S_SCANR;
          end
        end
        if (state_d == S_MARKR) begin
          rsp_d.start_block = pick_d[BaseW-1:0];
          if (end_d > NB) end_d = NB;
        end
      end
      S_MARKR: state_d = S_MARKW;
      S_MARKW: begin
        word_d = rdata; state_d = S_MARKM;
      end
      S_MARKM: begin
        // set or clear the bits of this word within [cur, end)
        for (int unsigned k = 0; k < WORD_BITS; k++) begin
          if ((IW'(widx(cur_q)) << BW) + IW'(k) >= cur_q &&
              (IW'(widx(cur_q)) << BW) + IW'(k) < end_q) begin
            wdata[k] = mark_used_q;
          end else begin
            wdata[k] = word_q[k];
          end
        end
        we = 1'b1;
        cur_d = (IW'(widx(cur_q)) + IW'(1)) << BW;
        state_d = (cur_d < end_q) ? S_MARKR : S_OUT;
      end
      S_QRYR: state_d = S_QRYW;
      S_QRYW: begin
        rsp_d.block_state = rdata[bidx(cur_q)]; state_d = S_OUT;
      end
      S_OUT: if (rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; policy_q <= FIT_FIRST; hint_q <= '0; clr_q <= '0;
    end else begin
      state_q <= state_d; hint_q <= hint_d; clr_q <= clr_d;
      if (cfg_i.valid) policy_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; rsp_q <= rsp_d; mark_used_q <= mark_used_d;
    cur_q <= cur_d; end_q <= end_d; it_q <= it_d; rstart_q <= rstart_d;
    rlen_q <= rlen_d; pick_q <= pick_d; plen_q <= plen_d; have_q <= have_d;
    word_q <= word_d;
  end
endmodule

// ----- rtl/bba_map_ram.sv -----
// Bitmap storage: one-write, one-read synchronous RAM, registered read.
// Depends on nothing.
module bba_map_ram #(
  parameter int unsigned Words = 128,
  parameter int unsigned WordBits = 32,
  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [WordBits-1:0] wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [WordBits-1:0] rdata_o
);
  logic [WordBits-1:0] mem [Words];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- bench/tb.sv -----
// Testbench for bitmap_block_allocator: random and directed allocate, free,
// reserve and query items, checked against a bitmap predictor in the bench.
// Depends on bba_pkg, bba_if and the allocator RTL.
`timescale 1ns / 100ps

module tb;
  import bba_pkg::*;

  localparam int unsigned NB = NumBlocksDef;
  localparam int unsigned MAX_CYCLES = 20000000;
  localparam int unsigned NO_RUN = 32'hFFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();
  bba_cfg_if cfg_if ();

  bitmap_block_allocator uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  // Predictor state
  bit [NB-1:0] used_bits = '1;
  int unsigned hint_blk = 0;
  logic [1:0] policy = FIT_FIRST;

  // Pending items and expected results
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int unsigned mismatches = 0;
  int unsigned rsp_count = 0;
  int unsigned cycle_count = 0;
  int unsigned op_seen[4] = '{0, 0, 0, 0};
  int unsigned nofit_seen = 0;
  bit send_enable = 1'b0;
  bit long_stall = 1'b0;
  bit stall_taken = 1'b0;
  int unsigned stall_len = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit blk_used(int unsigned b);
    if (b >= NB) return 1'b1;
    return used_bits[b];
  endfunction

  function automatic void mark_blocks(int unsigned base, int unsigned cnt, bit val);
    for (int unsigned k = 0; k < cnt; k++) begin
      if (base + k >= NB) break;
      used_bits[base + k] = val;
    end
  endfunction

  function automatic int unsigned find_first(int unsigned cnt);
    int unsigned s, len;
    s = 0;
    len = 0;
    for (int unsigned i = 0; i < NB; i++) begin
      if (used_bits[i]) begin
        len = 0;
      end else begin
        if (len == 0) s = i;
        len++;
        if (len >= cnt) return s;
      end
    end
    return NO_RUN;
  endfunction

  function automatic int unsigned find_next(int unsigned cnt);
    int unsigned s, len, i;
    s = 0;
    len = 0;
    if (hint_blk > 0 && !used_bits[hint_blk - 1]) hint_blk = 0;
    for (int unsigned it = 0; it < NB; it++) begin
      i = (it + hint_blk) % NB;
      if (i == 0) len = 0;
      if (used_bits[i]) begin
        len = 0;
      end else begin
        if (len == 0) s = i;
        len++;
        if (len >= cnt) begin
          hint_blk = (s + 1) % NB;
          return s;
        end
      end
    end
    return NO_RUN;
  endfunction

  // Best or worst fit; earliest run wins on ties
  function automatic int unsigned find_sized(int unsigned cnt, bit largest);
    int unsigned s, pick, pick_len, len;
    bit in_run, is_free;
    s = 0;
    pick = NO_RUN;
    pick_len = 0;
    in_run = 1'b0;
    for (int unsigned i = 0; i <= NB; i++) begin
      is_free = (i < NB) && !used_bits[i];
      if (is_free && !in_run) begin
        s = i;
        in_run = 1'b1;
      end else if (!is_free && in_run) begin
        in_run = 1'b0;
        len = i - s;
        if (len >= cnt) begin
          if (pick == NO_RUN || (largest ? len > pick_len : len < pick_len)) begin
            pick = s;
            pick_len = len;
          end
        end
      end
    end
    return pick;
  endfunction

  function automatic rsp_t predict_alloc_result(req_t r);
    rsp_t o;
    int unsigned cnt, hit;
    o = '0;
    cnt = r.block_count;
    case (r.opcode)
      OP_ALLOC: begin
        if (cnt == 0) begin
          o.status = ST_ZERO;
        end else begin
          if (policy == FIT_FIRST) hit = find_first(cnt);
          else if (policy == FIT_NEXT) hit = find_next(cnt);
          else hit = find_sized(cnt, policy == FIT_WORST);
          if (hit == NO_RUN) begin
            o.status = ST_NOFIT;
          end else begin
            mark_blocks(hit, cnt, 1'b1);
            o.start_block = hit[BaseW-1:0];
          end
        end
      end
      OP_FREE:    mark_blocks(r.base_block, cnt, 1'b0);
      OP_RESERVE: mark_blocks(r.base_block, cnt, 1'b1);
      default:    o.block_state = blk_used(r.base_block);
    endcase
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] op, int unsigned base, int unsigned cnt);
    req_t r;
    r.opcode = op;
    r.base_block = base[BaseW-1:0];
    r.block_count = cnt[CountW-1:0];
    return r;
  endfunction

  // Random count: mostly small, sometimes huge
  function automatic int unsigned rand_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 0;
    if (sel < 70) return $urandom_range(1, 40);
    if (sel < 90) return $urandom_range(41, 600);
    return $urandom_range(600, 8191);
  endfunction

  function automatic req_t rand_req();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return make_req(OP_ALLOC, $urandom_range(0, 4095), rand_count());
    if (sel < 70) return make_req(OP_FREE, $urandom_range(0, 4095), rand_count());
    if (sel < 85) return make_req(OP_RESERVE, $urandom_range(0, 4095), rand_count());
    return make_req(OP_QUERY, $urandom_range(0, 4095), $urandom_range(0, 8191));
  endfunction

  // Driver: bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(predict_alloc_result(req_if.data));
        op_seen[req_if.data.opcode]++;
      end
      if (req_if.valid && !req_if.ready) begin
        // hold current item
      end else if (send_enable && pending_reqs.size() > 0 && gap_left == 0) begin
        req_if.valid <= 1'b1;
        req_if.data <= pending_reqs.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        req_if.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off on request
  int unsigned stall_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (long_stall && !stall_taken) begin
        stall_taken = 1'b1;
        stall_len = 400;
      end
      if (long_stall && stall_len > 0) begin
        stall_len--;
        rsp_if.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: compare results in order
  rsp_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_count++;
        if (rsp_if.data.status == ST_NOFIT) nofit_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result %p", rsp_if.data);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected status=%0d start=%0d state=%0d, got %0d/%0d/%0d",
                       rsp_count, want.status, want.start_block, want.block_state,
                       rsp_if.data.status, rsp_if.data.start_block, rsp_if.data.block_state);
          end
        end
      end
      if (cycle_count > MAX_CYCLES) begin
        $display("ERROR: timeout");
        $display("FAIL bitmap_block_allocator");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_policy(logic [1:0] p);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= p;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    policy = p;
  endtask

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) pending_reqs.push_back(rand_req());
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all used at reset, extremes, all ops
    pending_reqs.push_back(make_req(OP_QUERY, 0, 0));
    pending_reqs.push_back(make_req(OP_QUERY, 4095, 8191));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, 1));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, 0));
    pending_reqs.push_back(make_req(OP_FREE, 0, 4096));
    pending_reqs.push_back(make_req(OP_ALLOC, 4095, 4096));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, 4097));
    pending_reqs.push_back(make_req(OP_FREE, 4090, 8191));
    pending_reqs.push_back(make_req(OP_QUERY, 4095, 0));
    pending_reqs.push_back(make_req(OP_RESERVE, 100, 0));
    pending_reqs.push_back(make_req(OP_RESERVE, 4000, 200));
    pending_reqs.push_back(make_req(OP_FREE, 10, 0));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, 8191));
    pending_reqs.push_back(make_req(OP_FREE, 1000, 50));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, 50));
    pending_reqs.push_back(make_req(OP_QUERY, 1049, 0));
    pending_reqs.push_back(make_req(OP_FREE, 0, 4096));
    send_enable = 1'b1;
    wait_drained();

    // Each policy, extremes first, then mostly random content
    foreach (op_seen[p]) begin
      write_policy(p[1:0]);
      // Fragment the map with a free then spaced reserves
      pending_reqs.push_back(make_req(OP_FREE, 0, 4096));
      for (int unsigned k = 0; k < 20; k++)
        pending_reqs.push_back(make_req(OP_RESERVE, $urandom_range(0, 4095),
                                        $urandom_range(1, 60)));
      pending_reqs.push_back(make_req(OP_ALLOC, 0, 4096));
      random_phase(100);
      if (p == 1) begin
        // Long receiver hold-off while the sender keeps offering
        long_stall = 1'b1;
      end
      wait_drained();
      long_stall = 1'b0;
    end
    write_policy(FIT_FIRST);
    random_phase(60);
    wait_drained();

    $display("Covered %0d alloc, %0d free, %0d reserve, %0d query items under all four policies;",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d results checked, %0d of them without a fitting run.", rsp_count, nofit_seen);
    if (mismatches == 0) begin
      $display("PASS bitmap_block_allocator");
    end else begin
      $display("ERROR: %0d mismatches", mismatches);
      $display("FAIL bitmap_block_allocator");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_map_ram.sv
rtl/bitmap_block_allocator.sv
bench/tb.sv
